@@ sv/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/acss_pkg.sv @@
package acss_pkg;

  // Fixed field widths
  localparam int MV_W       = 16;
  localparam int COUNTS_W   = 16;
  localparam int PERIOD_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = 2 * MV_W;

  // Q4.12 rounding: add half an LSB of the result, then drop the fraction
  localparam int                Q_FRAC     = 12;
  localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(1) << (Q_FRAC - 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BATT_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THROT_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET       = 3'd4;

  // Register reset values
  localparam logic [PERIOD_W-1:0] BATT_PERIOD_RST  = 32'd1000;
  localparam logic [PERIOD_W-1:0] THROT_PERIOD_RST = 32'd10;
  localparam logic [MV_W-1:0]     GAIN_RST         = 16'd20480;
  localparam logic [MV_W-1:0]     RATIO_RST        = 16'd45056;

  // Mux channel codes
  localparam logic [1:0] CH_NONE  = 2'd0;
  localparam logic [1:0] CH_BATT  = 2'd1;
  localparam logic [1:0] CH_THROT = 2'd2;

  typedef enum logic [1:0] {
    PH_INIT  = 2'd0,
    PH_IDLE  = 2'd1,
    PH_BATT  = 2'd2,
    PH_THROT = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_EVAL,
    C_MUL_GAIN,
    C_MUL_RATIO,
    C_OFFSET,
    C_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic                conv_done;
    logic [COUNTS_W-1:0] conv_counts;
    logic                throttle_enable;
  } in_item_t;

  typedef struct packed {
    logic            start_conversion;
    logic [1:0]      mux_channel;
    logic [MV_W-1:0] battery_mv;
    logic [MV_W-1:0] throttle_mv;
    logic            battery_updated;
    logic            throttle_updated;
    logic [1:0]      phase;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic eval;
    logic mul_gain;
    logic mul_ratio;
    logic offset;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scale_due;
    logic batt_pend;
    logic out_free;
  } dp_sts_t;

endpackage

@@ sv/acss_ctrl.sv @@
module acss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  acss_pkg::dp_sts_t sts,
  output acss_pkg::dp_cmd_t cmd
);
  import acss_pkg::*;

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      C_IDLE: begin
        if (in_valid) state_next = C_EVAL;
      end
      C_EVAL: begin
        state_next = sts.scale_due ? C_MUL_GAIN : C_OUT;
      end
      C_MUL_GAIN: begin
        state_next = sts.batt_pend ? C_MUL_RATIO : C_OUT;
      end
      C_MUL_RATIO: state_next = C_OFFSET;
      C_OFFSET:    state_next = C_OUT;
      C_OUT: begin
        if (sts.out_free) state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      C_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      C_EVAL:      cmd.eval      = 1'b1;
      C_MUL_GAIN:  cmd.mul_gain  = 1'b1;
      C_MUL_RATIO: cmd.mul_ratio = 1'b1;
      C_OFFSET:    cmd.offset    = 1'b1;
      C_OUT:       cmd.load_out  = sts.out_free;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ sv/acss_dp.sv @@
module acss_dp #(
  parameter int TICK_WIDTH   = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  acss_pkg::in_item_t            in_data,
  input  logic                          cfg_we,
  input  logic [acss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acss_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output acss_pkg::out_item_t           out_data,
  input  acss_pkg::dp_cmd_t             cmd,
  output acss_pkg::dp_sts_t             sts
);
  import acss_pkg::*;

  localparam int CMP_W = (TICK_WIDTH > PERIOD_W) ? TICK_WIDTH : PERIOD_W;

  // Configuration registers
  logic [PERIOD_W-1:0] batt_period;
  logic [PERIOD_W-1:0] throt_period;
  logic [MV_W-1:0]     gain;
  logic [MV_W-1:0]     ratio;
  logic [MV_W-1:0]     offset_mv;

  // Scheduler state
  phase_t                phase;
  phase_t                entered;
  logic [TICK_WIDTH-1:0] tick_count;
  logic [TICK_WIDTH-1:0] last_batt;
  logic [TICK_WIDTH-1:0] last_throt;
  logic                  first_run;
  logic [MV_W-1:0]       battery_value;
  logic [MV_W-1:0]       throttle_value;
  logic [1:0]            sel_channel;

  // Captured request and per-tick flags
  logic                    done_q;
  logic [SAMPLE_WIDTH-1:0] counts_q;
  logic                    ten_q;
  phase_t                  ran_q;
  logic                    start_q;
  logic                    bupd_q;
  logic                    tupd_q;
  logic [MV_W-1:0]         prod;

  // Elapsed checks, wrap-safe
  logic [TICK_WIDTH-1:0] batt_diff;
  logic [TICK_WIDTH-1:0] throt_diff;
  logic                  batt_due;
  logic                  throt_due;

  assign batt_diff  = tick_count - last_batt;
  assign throt_diff = tick_count - last_throt;
  assign batt_due   = CMP_W'(batt_diff) >= CMP_W'(batt_period);
  assign throt_due  = CMP_W'(throt_diff) >= CMP_W'(throt_period);

  // Shared Q4.12 multiplier with rounding and saturation
  logic [MV_W-1:0]   mul_a;
  logic [MV_W-1:0]   mul_b;
  logic [PROD_W-1:0] mul_full;
  logic [PROD_W:0]   mul_rnd;
  logic [PROD_W-Q_FRAC:0] mul_shift;
  logic [MV_W-1:0]   mul_sat;

  assign mul_a     = cmd.mul_ratio ? prod : MV_W'(counts_q);
  assign mul_b     = cmd.mul_ratio ? ratio : gain;
  assign mul_full  = mul_a * mul_b;
  assign mul_rnd   = {1'b0, mul_full} + ROUND_HALF;
  assign mul_shift = mul_rnd[PROD_W:Q_FRAC];
  assign mul_sat   = (|mul_shift[PROD_W-Q_FRAC:MV_W]) ? '1 : mul_shift[MV_W-1:0];

  // Offset add and clamp to 0..65535
  logic signed [MV_W+1:0] off_sum;
  logic [MV_W-1:0]        off_clamp;

  assign off_sum = $signed({2'b00, prod}) + $signed({{2{offset_mv[MV_W-1]}}, offset_mv});
  always_comb begin
    if (off_sum[MV_W+1]) begin
      off_clamp = '0;
    end else if (off_sum[MV_W]) begin
      off_clamp = '1;
    end else begin
      off_clamp = off_sum[MV_W-1:0];
    end
  end

  // Status to controller
  assign sts.scale_due = done_q && (phase == entered) &&
                         ((phase == PH_BATT) || (phase == PH_THROT));
  assign sts.batt_pend = bupd_q;
  assign sts.out_free  = !out_valid || !out_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      batt_period  <= BATT_PERIOD_RST;
      throt_period <= THROT_PERIOD_RST;
      gain         <= GAIN_RST;
      ratio        <= RATIO_RST;
      offset_mv    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BATT_PERIOD:  batt_period  <= cfg_data[PERIOD_W-1:0];
        REG_THROT_PERIOD: throt_period <= cfg_data[PERIOD_W-1:0];
        REG_GAIN:         gain         <= cfg_data[MV_W-1:0];
        REG_RATIO:        ratio        <= cfg_data[MV_W-1:0];
        REG_OFFSET:       offset_mv    <= cfg_data[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      done_q   <= in_data.conv_done;
      counts_q <= in_data.conv_counts[SAMPLE_WIDTH-1:0];
      ten_q    <= in_data.throttle_enable;
    end
  end

  // Advance the scheduler by one tick, then run the scaling steps
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_INIT;
      entered        <= PH_INIT;
      tick_count     <= '0;
      last_batt      <= '0;
      last_throt     <= '0;
      first_run      <= 1'b1;
      battery_value  <= '0;
      throttle_value <= '0;
      sel_channel    <= CH_NONE;
      bupd_q         <= 1'b0;
      tupd_q         <= 1'b0;
      start_q        <= 1'b0;
      ran_q          <= PH_INIT;
    end else begin
      if (cmd.eval) begin
        ran_q      <= phase;
        start_q    <= 1'b0;
        bupd_q     <= 1'b0;
        tupd_q     <= 1'b0;
        tick_count <= tick_count + TICK_WIDTH'(1);
        case (phase)
          PH_INIT: begin
            sel_channel <= CH_NONE;
            phase       <= PH_IDLE;
          end
          PH_IDLE: begin
            entered <= PH_IDLE;
            if (batt_due) begin
              phase <= PH_BATT;
            end else if (ten_q && throt_due) begin
              phase <= PH_THROT;
            end else if (first_run) begin
              phase     <= PH_BATT;
              first_run <= 1'b0;
            end
          end
          PH_BATT: begin
            if (entered != PH_BATT) begin
              sel_channel <= CH_BATT;
              start_q     <= 1'b1;
              last_batt   <= tick_count;
              entered     <= PH_BATT;
            end else if (done_q) begin
              bupd_q <= 1'b1;
              phase  <= PH_IDLE;
            end
          end
          default: begin
            if (entered != PH_THROT) begin
              sel_channel <= CH_THROT;
              start_q     <= 1'b1;
              last_throt  <= tick_count;
              entered     <= PH_THROT;
            end else if (done_q) begin
              tupd_q <= 1'b1;
              phase  <= PH_IDLE;
            end
          end
        endcase
      end
      if (cmd.mul_gain && tupd_q) begin
        throttle_value <= mul_sat;
      end
      if (cmd.offset) begin
        battery_value <= off_clamp;
      end
    end
  end

  // Product register between multiplier steps
  always_ff @(posedge clk) begin
    if (cmd.mul_gain || cmd.mul_ratio) begin
      prod <= mul_sat;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.start_conversion <= start_q;
      out_data.mux_channel      <= sel_channel;
      out_data.battery_mv       <= battery_value;
      out_data.throttle_mv      <= throttle_value;
      out_data.battery_updated  <= bupd_q;
      out_data.throttle_updated <= tupd_q;
      out_data.phase            <= ran_q;
    end
  end

endmodule

@@ sv/adc_two_channel_sampling_scheduler_top.sv @@
// Two-channel converter sampling scheduler. Each request is one tick carrying the
// converter done flag, its counts and the throttle enable; each tick yields exactly
// one result with the start pulse, mux channel, latest battery and throttle
// millivolts, update flags and the phase that ran. After the request is accepted
// the controller steps through evaluate and then the output load when no
// conversion completes; a throttle conversion adds the gain step, and a battery
// conversion adds the gain, divider-ratio and offset steps. The extra steps go
// through the single shared 16x16 Q4.12 multiplier (gain, then divider ratio)
// and the offset clamp. The input is taken again in the cycle after the result
// is loaded. Only one tick is in flight at a time; a stalled output delays the
// loading of the result and so the next tick.
module adc_two_channel_sampling_scheduler_top #(
  parameter int TICK_WIDTH   = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  acss_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output acss_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [acss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import acss_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  acss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  acss_dp #(
    .TICK_WIDTH   (TICK_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ sv/acss_checker.sv @@
`include "assert_macros.svh"

module acss_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input acss_pkg::out_item_t out_data
);
  import acss_pkg::*;

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // One tick in flight: an accepted request stalls the input next cycle
  `ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && !in_stall, in_stall, "second request taken while busy")

  // Start pulse only on a measuring phase with its channel selected
  `ASSERT_SAME(a_start_chan, clk, rst, out_valid && out_data.start_conversion, (out_data.phase == PH_BATT && out_data.mux_channel == CH_BATT) || (out_data.phase == PH_THROT && out_data.mux_channel == CH_THROT), "start without matching channel")

  // Battery refresh only ends a battery measurement
  `ASSERT_SAME(a_batt_upd, clk, rst, out_valid && out_data.battery_updated, out_data.phase == PH_BATT && !out_data.start_conversion && !out_data.throttle_updated, "bad battery update")

  // Init tick deselects the mux
  `ASSERT_SAME(a_init_none, clk, rst, out_valid && out_data.phase == PH_INIT, out_data.mux_channel == CH_NONE && !out_data.start_conversion, "init tick left a channel selected")

endmodule

bind adc_two_channel_sampling_scheduler_top acss_checker u_acss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ bench/adc_two_channel_sampling_scheduler_top_tb.sv @@
`timescale 1ns / 100ps

module adc_two_channel_sampling_scheduler_top_tb;
  import acss_pkg::*;

  localparam int STUCK_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 8;
  localparam int RANDOM_SETS  = 8;
  localparam int SET_TICKS    = 56;

  // Tracks the scheduler state and holds the results owed for accepted ticks
  class sched_tracker;
    logic [PERIOD_W-1:0] batt_period;
    logic [PERIOD_W-1:0] throt_period;
    logic [MV_W-1:0]     gain;
    logic [MV_W-1:0]     ratio;
    shortint             offset_mv;

    phase_t              cur_phase;
    phase_t              entered;
    logic [31:0]         tick;
    logic [31:0]         last_batt;
    logic [31:0]         last_throt;
    bit                  first_run;
    logic [MV_W-1:0]     batt_mv;
    logic [MV_W-1:0]     throt_mv;
    logic [1:0]          sel;

    out_item_t           owed[$];
    int                  errors;

    function new();
      batt_period  = BATT_PERIOD_RST;
      throt_period = THROT_PERIOD_RST;
      gain         = GAIN_RST;
      ratio        = RATIO_RST;
      offset_mv    = 0;
      cur_phase    = PH_INIT;
      entered      = PH_INIT;
      tick         = '0;
      last_batt    = '0;
      last_throt   = '0;
      first_run    = 1'b1;
      batt_mv      = '0;
      throt_mv     = '0;
      sel          = CH_NONE;
      errors       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BATT_PERIOD:  batt_period = data;
        REG_THROT_PERIOD: throt_period = data;
        REG_GAIN:         gain = data[MV_W-1:0];
        REG_RATIO:        ratio = data[MV_W-1:0];
        REG_OFFSET:       offset_mv = shortint'(data[MV_W-1:0]);
        default: ;
      endcase
    endfunction

    // Q4.12 multiply, round half up, saturate to the millivolt range
    function logic [MV_W-1:0] q12_scale(logic [MV_W-1:0] a, logic [MV_W-1:0] q);
      longint p;
      p = (longint'(a) * longint'(q) + 2048) >> Q_FRAC;
      return (p > 65535) ? 16'hFFFF : p[MV_W-1:0];
    endfunction

    // Wrap-safe elapsed test on the tick counter
    function bit due(logic [31:0] last, logic [31:0] period);
      logic [31:0] diff;
      diff = tick - last;
      return diff >= period;
    endfunction

    function void take_tick(in_item_t req);
      out_item_t r;
      phase_t    ran;
      longint    v;
      ran = cur_phase;
      r = '0;
      case (ran)
        PH_INIT: begin
          sel = CH_NONE;
          cur_phase = PH_IDLE;
        end
        PH_IDLE: begin
          entered = PH_IDLE;
          if (due(last_batt, batt_period)) begin
            cur_phase = PH_BATT;
          end else if (req.throttle_enable && due(last_throt, throt_period)) begin
            cur_phase = PH_THROT;
          end else if (first_run) begin
            cur_phase = PH_BATT;
            first_run = 1'b0;
          end
        end
        PH_BATT: begin
          if (entered != PH_BATT) begin
            sel = CH_BATT;
            r.start_conversion = 1'b1;
            last_batt = tick;
            entered = PH_BATT;
          end else if (req.conv_done) begin
            v = longint'(q12_scale(q12_scale(req.conv_counts, gain), ratio)) +
                longint'(offset_mv);
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            batt_mv = v[MV_W-1:0];
            r.battery_updated = 1'b1;
            cur_phase = PH_IDLE;
          end
        end
        default: begin
          if (entered != PH_THROT) begin
            sel = CH_THROT;
            r.start_conversion = 1'b1;
            last_throt = tick;
            entered = PH_THROT;
          end else if (req.conv_done) begin
            throt_mv = q12_scale(req.conv_counts, gain);
            r.throttle_updated = 1'b1;
            cur_phase = PH_IDLE;
          end
        end
      endcase
      tick = tick + 1;
      r.mux_channel = sel;
      r.battery_mv  = batt_mv;
      r.throttle_mv = throt_mv;
      r.phase       = ran;
      owed.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        $error("result arrived with no tick waiting for it");
        errors++;
        return;
      end
      want = owed.pop_front();
      check_field("start_conversion", 32'(want.start_conversion),
                  32'(got.start_conversion));
      check_field("mux_channel", 32'(want.mux_channel), 32'(got.mux_channel));
      check_field("battery_mv", 32'(want.battery_mv), 32'(got.battery_mv));
      check_field("throttle_mv", 32'(want.throttle_mv), 32'(got.throttle_mv));
      check_field("battery_updated", 32'(want.battery_updated),
                  32'(got.battery_updated));
      check_field("throttle_updated", 32'(want.throttle_updated),
                  32'(got.throttle_updated));
      check_field("phase", 32'(want.phase), 32'(got.phase));
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sched_tracker sched = new();
  bit           no_idle = 1'b0;
  int           done_pct = 40;
  int           enable_pct = 75;
  int           stuck_cycles = 0;

  adc_two_channel_sampling_scheduler_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count cycles in which neither side moves anything
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic in_item_t make_tick(bit done, logic [COUNTS_W-1:0] counts, bit en);
    in_item_t t;
    t.conv_done       = done;
    t.conv_counts     = counts;
    t.throttle_enable = en;
    return t;
  endfunction

  function automatic in_item_t random_tick();
    logic [COUNTS_W-1:0] counts;
    case ($urandom_range(0, 7))
      0:       counts = '0;
      1:       counts = '1;
      default: counts = COUNTS_W'($urandom());
    endcase
    return make_tick($urandom_range(0, 99) < done_pct, counts,
                     $urandom_range(0, 99) < enable_pct);
  endfunction

  function automatic logic [PERIOD_W-1:0] random_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  function automatic logic [MV_W-1:0] random_q12();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return MV_W'($urandom_range(0, 65535));
      default: return MV_W'($urandom_range(512, 12288));
    endcase
  endfunction

  // Present one tick after a random gap and hold it until accepted
  task automatic send_tick(input in_item_t req);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sched.take_tick(req);
  endtask

  // Drop valid and let every owed result drain before touching registers
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (sched.pending() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sched.set_reg(idx, data);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [PERIOD_W-1:0] bp, input logic [PERIOD_W-1:0] tp,
                           input logic [MV_W-1:0] g, input logic [MV_W-1:0] r,
                           input logic [MV_W-1:0] off);
    write_reg(REG_BATT_PERIOD, bp);
    write_reg(REG_THROT_PERIOD, tp);
    write_reg(REG_GAIN, {16'h0, g});
    write_reg(REG_RATIO, {16'h0, r});
    write_reg(REG_OFFSET, {16'h0, off});
  endtask

  task automatic send_random(input int n);
    repeat (n) send_tick(random_tick());
  endtask

  // Result side: stall for a drawn number of cycles, then take one result
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      sched.check_result(out_data);
    end
  end

  initial begin : stimulus
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Reset settings: init, power-up battery, done on entry, saturation,
    // throttle due, enable dropped while throttle is measuring
    send_tick(make_tick(1'b1, 16'hFFFF, 1'b1));
    send_tick(make_tick(1'b0, 16'h0000, 1'b0));
    send_tick(make_tick(1'b1, 16'h1234, 1'b1));
    send_tick(make_tick(1'b1, 16'hFFFF, 1'b1));
    send_tick(make_tick(1'b0, 16'h8000, 1'b1));
    send_tick(make_tick(1'b1, 16'h7FFF, 1'b1));
    send_tick(make_tick(1'b0, 16'h0001, 1'b1));
    send_tick(make_tick(1'b0, 16'hAAAA, 1'b1));
    send_tick(make_tick(1'b0, 16'h5555, 1'b1));
    send_tick(make_tick(1'b0, 16'h0000, 1'b1));
    send_tick(make_tick(1'b0, 16'h0000, 1'b1));
    send_tick(make_tick(1'b1, 16'h8000, 1'b0));
    send_tick(make_tick(1'b0, 16'hFFFF, 1'b0));
    send_tick(make_tick(1'b1, 16'h0001, 1'b0));
    send_tick(make_tick(1'b1, 16'h0000, 1'b0));
    settle();

    // Zero periods and full-scale gains with the largest offset, no idling
    no_idle = 1'b1;
    write_all('0, '0, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    send_random(12);
    settle();

    // Longest battery period, zero gains, most negative offset
    no_idle = 1'b0;
    write_all('1, 32'd1, 16'h0000, 16'h0000, 16'h8000);
    send_random(12);
    settle();

    // Unity gains with a deep negative offset so the clamp at zero is hit
    write_all(32'd3, 32'd2, 16'h1000, 16'h1000, 16'h8000);
    send_random(12);
    settle();

    // Random settings, some without idling on either side
    for (int s = 0; s < RANDOM_SETS; s++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      write_all(random_period(), random_period(), random_q12(), random_q12(),
                MV_W'($urandom_range(0, 65535)));
      send_random(SET_TICKS);
      settle();
    end

    if (sched.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
